// ===== rtl/core/lrmf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lrmf_pkg;

    // fixed field widths
    localparam int RATE_W       = 20;
    localparam int BUF_W        = 24;
    localparam int TALLY_W      = 20;
    localparam int US_W         = 44;
    localparam int IN_DLY_W     = 25;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 24;
    localparam int IN_TDATA_W   = 32;

    // defaults for the top level parameters
    localparam int WINDOW_DEPTH_DEF = 32;
    localparam int DELAY_WIDTH_DEF  = 24;

    // constants of the filter
    localparam int MIN_SAMPLES = 5;
    localparam logic [TALLY_W-1:0] REJECT_CAP = TALLY_W'(1000000);
    localparam logic [RATE_W-1:0]  US_PER_S   = RATE_W'(1000000);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_FRAMES = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_TAIL,
        S_DIV_START,
        S_DIV_WAIT,
        S_OUT
    } lrmf_state_t;

    typedef enum logic [1:0] {
        SEL_MIN,
        SEL_MAX,
        SEL_MED
    } div_sel_t;

    typedef struct packed {
        logic     apply;
        logic     scan_en;
        logic     div_start;
        div_sel_t div_sel;
        logic     load_out;
    } lrmf_cmd_t;

    typedef struct packed {
        logic range_known;
        logic med_known;
        logic scan_last;
        logic div_done;
        logic out_busy;
    } lrmf_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/latency_rolling_median_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Rolling median of stream delay readings.
// Input channel s_axis_*: one status poll per beat. tdata bit 0 status readable,
// bit 1 stream running, bit 2 delay reported, bits 27:3 signed delay in frames.
// Output channel m_axis_*: one result beat per poll with running flag, window
// fill, reject count, upper median, minimum and maximum in microseconds.
// Configuration: cfg_we/cfg_index/cfg_data, index 0 sample rate, 1 buffer frames;
// write only while no poll is in flight.
// Operation: a poll is taken, then the window is ranked by scanning the
// window memory, reading each held reading as a candidate and then all held
// readings against it, and each of up to three conversions runs on a shared
// restoring divider. With no readings or zero rate the scan and the
// conversions are skipped.
// One poll is worked on at a time; s_axis_tready is high only between polls.
// A finished result waits in the output register while the receiver stalls,
// and the next poll may be accepted meanwhile; its result waits for the slot.
// Reset empties the window, clears the running flag, the reject count and
// both registers, and drops any pending result.
module latency_rolling_median_filter
    import lrmf_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int DELAY_WIDTH  = DELAY_WIDTH_DEF,
    parameter int CW           = $clog2(WINDOW_DEPTH + 1),
    parameter int OUT_TDATA_W  = ((4 + CW + TALLY_W + 3 * US_W) + 7) / 8 * 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // status_readable, stream_running, delay_reported, delay_frames, zero pad
    input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // is_running, sample_count, rejected_count, median_known, median_us,
    // range_known, min_us, max_us, zero pad
    output logic [OUT_TDATA_W-1:0]     m_axis_tdata
);

    lrmf_cmd_t    cmd;
    lrmf_status_t status;

    lrmf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tvalid (s_axis_tvalid),
        .in_tready (s_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    lrmf_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .DELAY_WIDTH  (DELAY_WIDTH),
        .CW           (CW),
        .OUT_TDATA_W  (OUT_TDATA_W)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_tdata   (s_axis_tdata),
        .out_tvalid (m_axis_tvalid),
        .out_tready (m_axis_tready),
        .out_tdata  (m_axis_tdata),
        .cmd        (cmd),
        .status     (status)
    );

endmodule

`default_nettype wire

// ===== rtl/core/lrmf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lrmf_ctrl
    import lrmf_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_tvalid,
    output logic              in_tready,
    input  wire lrmf_status_t status,
    output lrmf_cmd_t         cmd
);

    lrmf_state_t state_reg, state_next;
    div_sel_t    sel_reg, sel_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= SEL_MIN;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        sel_next      = sel_reg;
        in_tready     = 1'b0;
        cmd           = '0;
        cmd.div_sel   = sel_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_tready = 1'b1;
                if (in_tvalid)
                begin
                    cmd.apply  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = status.range_known ? S_SCAN : S_OUT;
            end
            S_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                sel_next   = SEL_MIN;
                state_next = S_DIV_START;
            end
            S_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    unique case (sel_reg)
                        SEL_MIN:
                        begin
                            sel_next   = SEL_MAX;
                            state_next = S_DIV_START;
                        end
                        SEL_MAX:
                        begin
                            if (status.med_known)
                            begin
                                sel_next   = SEL_MED;
                                state_next = S_DIV_START;
                            end
                            else
                            begin
                                state_next = S_OUT;
                            end
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/lrmf_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lrmf_datapath
    import lrmf_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int DELAY_WIDTH  = DELAY_WIDTH_DEF,
    parameter int CW           = $clog2(WINDOW_DEPTH + 1),
    parameter int OUT_TDATA_W  = ((4 + CW + TALLY_W + 3 * US_W) + 7) / 8 * 8
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic [IN_TDATA_W-1:0]  in_tdata,
    output logic                        out_tvalid,
    input  wire logic                   out_tready,
    output logic [OUT_TDATA_W-1:0]      out_tdata,
    input  wire lrmf_cmd_t              cmd,
    output lrmf_status_t                status
);

    localparam int AW  = $clog2(WINDOW_DEPTH);
    localparam int PW  = DELAY_WIDTH + RATE_W;
    localparam int DCW = $clog2(PW + 1);

    // configuration
    logic [RATE_W-1:0] rate_reg;
    logic [BUF_W-1:0]  buf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= '0;
            buf_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SAMPLE_RATE:   rate_reg <= cfg_data[RATE_W-1:0];
                REG_BUFFER_FRAMES: buf_reg  <= cfg_data[BUF_W-1:0];
                default:           ;
            endcase
        end
    end

    // input fields
    logic                       readable, running, reported;
    logic signed [IN_DLY_W-1:0] dly;
    logic [BUF_W-1:0]           limit;
    logic                       plausible;
    logic [31:0]                dly32;
    logic [DELAY_WIDTH-1:0]     dly_val;

    assign readable  = in_tdata[0];
    assign running   = in_tdata[1];
    assign reported  = in_tdata[2];
    assign dly       = in_tdata[27:3];
    assign limit     = (buf_reg != '0) ? buf_reg : BUF_W'(rate_reg);
    assign plausible = !dly[IN_DLY_W-1] && (dly[BUF_W-1:0] != '0)
                       && (dly[BUF_W-1:0] <= limit);
    assign dly32     = {8'b0, dly[BUF_W-1:0]};
    assign dly_val   = dly32[DELAY_WIDTH-1:0];

    // window state
    logic [DELAY_WIDTH-1:0] mem [WINDOW_DEPTH];
    logic [CW-1:0]          fill_reg;
    logic [AW-1:0]          oldest_reg;
    logic                   run_reg;
    logic [TALLY_W-1:0]     tally_reg;
    logic                   full;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;

    assign full    = (fill_reg == CW'(WINDOW_DEPTH));
    assign wr_en   = cmd.apply && readable && running && (rate_reg != '0)
                     && reported && plausible;
    assign wr_addr = full ? oldest_reg : fill_reg[AW-1:0];

    // poll update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            oldest_reg <= '0;
            run_reg    <= 1'b0;
            tally_reg  <= '0;
        end
        else if (cmd.apply)
        begin
            if (!readable)
            begin
                run_reg    <= 1'b0;
                fill_reg   <= '0;
                oldest_reg <= '0;
            end
            else if (!running)
            begin
                if (run_reg)
                begin
                    fill_reg   <= '0;
                    oldest_reg <= '0;
                end
                run_reg <= 1'b0;
            end
            else
            begin
                run_reg <= 1'b1;
                if ((rate_reg != '0) && reported)
                begin
                    if (!plausible)
                    begin
                        if (tally_reg < REJECT_CAP)
                        begin
                            tally_reg <= tally_reg + 1'b1;
                        end
                    end
                    else if (full)
                    begin
                        oldest_reg <= (oldest_reg == AW'(WINDOW_DEPTH - 1)) ? '0
                                      : oldest_reg + 1'b1;
                    end
                    else
                    begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                end
            end
        end
    end

    // scan issue counters: candidate read, then all entries
    logic [AW-1:0] i_reg;
    logic [CW-1:0] ph_reg;
    logic [CW-1:0] fill_m1;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] ph_m1;
    logic          ph_end;

    assign fill_m1 = fill_reg - 1'b1;
    assign ph_m1   = ph_reg - 1'b1;
    assign ph_end  = (ph_reg == fill_reg);
    assign rd_addr = (ph_reg == '0) ? i_reg : ph_m1[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg  <= '0;
            ph_reg <= '0;
        end
        else if (cmd.apply)
        begin
            i_reg  <= '0;
            ph_reg <= '0;
        end
        else if (cmd.scan_en)
        begin
            if (ph_end)
            begin
                ph_reg <= '0;
                i_reg  <= i_reg + 1'b1;
            end
            else
            begin
                ph_reg <= ph_reg + 1'b1;
            end
        end
    end

    // memory ports
    logic [DELAY_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= dly_val;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // read tags
    logic tag_vld_reg, tag_cand_reg, tag_first_reg, tag_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_vld_reg   <= 1'b0;
            tag_cand_reg  <= 1'b0;
            tag_first_reg <= 1'b0;
            tag_last_reg  <= 1'b0;
        end
        else
        begin
            tag_vld_reg   <= cmd.scan_en;
            tag_cand_reg  <= (ph_reg == '0);
            tag_first_reg <= (i_reg == '0);
            tag_last_reg  <= ph_end;
        end
    end

    // rank counting, min and max
    logic [DELAY_WIDTH-1:0] cand_reg, min_reg, max_reg, med_reg;
    logic [CW-1:0]          lt_reg, le_reg, lt_n, le_n, k;

    assign k    = fill_reg >> 1;
    assign lt_n = lt_reg + CW'(rd_data_reg < cand_reg);
    assign le_n = le_reg + CW'(rd_data_reg <= cand_reg);

    always_ff @(posedge clk)
    begin
        if (tag_vld_reg)
        begin
            if (tag_cand_reg)
            begin
                cand_reg <= rd_data_reg;
                lt_reg   <= '0;
                le_reg   <= '0;
                if (tag_first_reg || rd_data_reg < min_reg)
                begin
                    min_reg <= rd_data_reg;
                end
                if (tag_first_reg || rd_data_reg > max_reg)
                begin
                    max_reg <= rd_data_reg;
                end
            end
            else
            begin
                lt_reg <= lt_n;
                le_reg <= le_n;
                if (tag_last_reg && (lt_n <= k) && (k < le_n))
                begin
                    med_reg <= cand_reg;
                end
            end
        end
    end

    // restoring divider, one quotient bit per cycle
    logic [PW-1:0]          quo_reg;
    logic [RATE_W:0]        rem_reg;
    logic [DCW-1:0]         dcnt_reg;
    logic                   done_reg;
    div_sel_t               dsel_reg;
    logic [DELAY_WIDTH-1:0] frames;
    logic [RATE_W:0]        rem_sh;
    logic                   ge;
    logic [63:0]            q64;

    assign rem_sh = {rem_reg[RATE_W-1:0], quo_reg[PW-1]};
    assign ge     = (rem_sh >= {1'b0, rate_reg});
    assign q64    = 64'(quo_reg);

    always_comb
    begin
        case (cmd.div_sel)
            SEL_MIN: frames = min_reg;
            SEL_MAX: frames = max_reg;
            default: frames = med_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else if (cmd.div_start)
        begin
            dcnt_reg <= DCW'(PW);
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (dcnt_reg == DCW'(1));
            if (dcnt_reg != '0)
            begin
                dcnt_reg <= dcnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            quo_reg  <= PW'(frames) * PW'(US_PER_S);
            rem_reg  <= '0;
            dsel_reg <= cmd.div_sel;
        end
        else if (dcnt_reg != '0)
        begin
            rem_reg <= ge ? rem_sh - {1'b0, rate_reg} : rem_sh;
            quo_reg <= {quo_reg[PW-2:0], ge};
        end
    end

    // converted results
    logic [US_W-1:0] min_us_reg, max_us_reg, med_us_reg;

    always_ff @(posedge clk)
    begin
        if (done_reg)
        begin
            case (dsel_reg)
                SEL_MIN: min_us_reg <= q64[US_W-1:0];
                SEL_MAX: max_us_reg <= q64[US_W-1:0];
                default: med_us_reg <= q64[US_W-1:0];
            endcase
        end
    end

    // output register
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                   rng_known, med_known;

    assign rng_known = (rate_reg != '0) && (fill_reg != '0);
    assign med_known = (rate_reg != '0) && (fill_reg >= CW'(MIN_SAMPLES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg <= OUT_TDATA_W'({
                rng_known ? max_us_reg : {US_W{1'b0}},
                rng_known ? min_us_reg : {US_W{1'b0}},
                rng_known,
                med_known ? med_us_reg : {US_W{1'b0}},
                med_known,
                tally_reg,
                fill_reg,
                run_reg
            });
        end
    end

    assign out_tvalid = out_valid_reg;
    assign out_tdata  = out_data_reg;

    assign status = '{
        range_known: rng_known,
        med_known:   med_known,
        scan_last:   (i_reg == fill_m1[AW-1:0]) && ph_end,
        div_done:    done_reg,
        out_busy:    out_valid_reg && !out_tready
    };

    // checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(WINDOW_DEPTH))
        else $error("window fill above depth");

    a_oldest_full: assert property (@(posedge clk) disable iff (!rst_n)
        (oldest_reg != '0) |-> full)
        else $error("oldest slot moved before window was full");

    a_tally_cap: assert property (@(posedge clk) disable iff (!rst_n)
        tally_reg <= REJECT_CAP)
        else $error("reject count above cap");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_tready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("pending result overwritten");

endmodule

`default_nettype wire
